// ===== rtl/core/ipm_pkg.sv =====
// ----------------------------------------------------------------------------
// ipm_pkg
// Shared types and constants for the inverter protection monitor: frame and
// result layouts, register indexes, flag bit positions and raw-code
// thresholds.
// ----------------------------------------------------------------------------
package ipm_pkg;

  localparam int ADC_BITS = 12;
  localparam int ADC_FS   = (1 << ADC_BITS) - 1;
  localparam int ADC_MID  = 1 << (ADC_BITS - 1);

  // currents: signed counts from midscale, magnitude one bit wider than the code
  localparam int CUR_W  = ADC_BITS + 2;
  localparam int PEAK_W = ADC_BITS + 1;
  localparam int THR_W  = ADC_BITS + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int LIMIT_W    = 13;
  localparam int FLAGS_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BUS_HV   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OC_LIMIT = CFG_IDX_W'(1);

  localparam logic             BUS_HV_RST   = 1'b1;
  localparam logic [LIMIT_W-1:0] OC_LIMIT_RST = LIMIT_W'(1024);

  localparam int FLAG_BUS  = 0;
  localparam int FLAG_OC   = 1;
  localparam int FLAG_TEMP = 2;
  localparam int FLAG_DRV  = 3;

  // bus and temperature limits in volts and degrees
  localparam int LV_SCALE   = 60;
  localparam int LV_ON      = 54;
  localparam int LV_OFF     = 51;
  localparam int LV_UNDER   = 36;
  localparam int LV_OVER    = 58;
  localparam int HV_SCALE   = 450;
  localparam int HV_ON      = 440;
  localparam int HV_OFF     = 410;
  localparam int HV_UNDER   = 300;
  localparam int HV_OVER    = 480;
  localparam int TEMP_SCALE = 125;
  localparam int TEMP_LIMIT = 105;

  // code thresholds: >= and < use the ceiling, <= and > use the floor
  localparam int LV_ON_CODE    = (LV_ON * ADC_FS + LV_SCALE - 1) / LV_SCALE;
  localparam int LV_OFF_CODE   = (LV_OFF * ADC_FS) / LV_SCALE;
  localparam int LV_UNDER_CODE = (LV_UNDER * ADC_FS + LV_SCALE - 1) / LV_SCALE;
  localparam int LV_OVER_CODE  = (LV_OVER * ADC_FS) / LV_SCALE;
  localparam int HV_ON_CODE    = (HV_ON * ADC_FS + HV_SCALE - 1) / HV_SCALE;
  localparam int HV_OFF_CODE   = (HV_OFF * ADC_FS) / HV_SCALE;
  localparam int HV_UNDER_CODE = (HV_UNDER * ADC_FS + HV_SCALE - 1) / HV_SCALE;
  localparam int HV_OVER_CODE  = (HV_OVER * ADC_FS) / HV_SCALE;
  localparam int TEMP_CODE     = (TEMP_LIMIT * ADC_FS) / TEMP_SCALE;

  localparam logic [THR_W-1:0] LV_ON_THR    = THR_W'(LV_ON_CODE);
  localparam logic [THR_W-1:0] LV_OFF_THR   = THR_W'(LV_OFF_CODE);
  localparam logic [THR_W-1:0] LV_UNDER_THR = THR_W'(LV_UNDER_CODE);
  localparam logic [THR_W-1:0] LV_OVER_THR  = THR_W'(LV_OVER_CODE);
  localparam logic [THR_W-1:0] HV_ON_THR    = THR_W'(HV_ON_CODE);
  localparam logic [THR_W-1:0] HV_OFF_THR   = THR_W'(HV_OFF_CODE);
  localparam logic [THR_W-1:0] HV_UNDER_THR = THR_W'(HV_UNDER_CODE);
  localparam logic [THR_W-1:0] HV_OVER_THR  = THR_W'(HV_OVER_CODE);
  localparam logic [THR_W-1:0] TEMP_THR     = THR_W'(TEMP_CODE);

  localparam logic [CUR_W-1:0] MID_CUR = CUR_W'(ADC_MID);

  typedef struct packed {
    logic [ADC_BITS-1:0] adc_phase_u;
    logic [ADC_BITS-1:0] adc_phase_v;
    logic [ADC_BITS-1:0] adc_bus;
    logic [ADC_BITS-1:0] adc_temp_motor;
    logic [ADC_BITS-1:0] adc_temp_driver;
    logic                driver_fault;
    logic                target_nonzero;
    logic                brake_hold;
  } in_item_t;

  typedef struct packed {
    logic               drive_allowed;
    logic               chopper_on;
    logic               gate_kill;
    logic [FLAGS_W-1:0] fault_flags;
    logic [PEAK_W-1:0]  peak_current;
  } out_item_t;

  typedef struct packed {
    logic               bus_high_voltage;
    logic [LIMIT_W-1:0] overcurrent_limit;
  } cfg_t;

  typedef struct packed {
    logic               chopper;
    logic [FLAGS_W-1:0] flags;
  } prot_state_t;

endpackage

// ===== rtl/core/inverter_protection_monitor.sv =====
// ----------------------------------------------------------------------------
// inverter_protection_monitor
// Sample-frame protection monitor: brake chopper hysteresis, sticky fault
// flags, gate kill and peak phase current, one result per frame.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------
//   in      | input     | in_valid / in_ready    | in_data  (in_item_t)
//   out     | output    | out_valid / out_ready  | out_data (out_item_t)
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one frame per cycle sustained while out_ready stays high; a frame passes
// through the input register, evaluation and the result register, and its
// result is valid once it is held in the result register
// synchronous active-low reset clears valid bits, chopper and flags, and
// loads the register defaults
// when out_ready is low the result register holds; in_ready drops once the
// input register is also full
// cfg_ready is always high
// ----------------------------------------------------------------------------
module inverter_protection_monitor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ipm_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ipm_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ipm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ipm_pkg::*;

  cfg_t        cfg;
  in_item_t    frame_r;
  logic        frame_vld_r;
  out_item_t   res_r;
  logic        res_vld_r;
  prot_state_t state_r, state_nxt;
  out_item_t   res_nxt;
  logic        res_adv, frame_adv;

  assign cfg_ready = 1'b1;

  ipm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ipm_eval u_eval (
    .frame     (frame_r),
    .cfg       (cfg),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  assign res_adv   = !res_vld_r || out_ready;
  assign frame_adv = frame_vld_r && res_adv;
  assign in_ready  = !frame_vld_r || res_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_vld_r   <= 1'b0;
      res_vld_r     <= 1'b0;
      state_r       <= '0;
    end else begin
      if (in_ready) frame_vld_r <= in_valid;
      if (res_adv)  res_vld_r   <= frame_vld_r;
      if (frame_adv) state_r    <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) frame_r <= in_data;
    if (frame_adv)            res_r   <= res_nxt;
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

// ===== rtl/core/ipm_cfg.sv =====
// ----------------------------------------------------------------------------
// ipm_cfg
// Configuration registers: bus range select and overcurrent limit.
// ----------------------------------------------------------------------------
module ipm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [ipm_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [ipm_pkg::CFG_DATA_W-1:0]   wr_data,
  output ipm_pkg::cfg_t                    cfg
);
  import ipm_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_BUS_HV:   cfg_nxt.bus_high_voltage  = wr_data[0];
        REG_OC_LIMIT: cfg_nxt.overcurrent_limit = wr_data[LIMIT_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_high_voltage  <= BUS_HV_RST;
      cfg_r.overcurrent_limit <= OC_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/ipm_eval.sv =====
// ----------------------------------------------------------------------------
// ipm_eval
// Per-frame evaluation: third phase current, peak magnitude, chopper
// hysteresis and fault detection against raw-code thresholds.
// ----------------------------------------------------------------------------
module ipm_eval (
  input  ipm_pkg::in_item_t    frame,
  input  ipm_pkg::cfg_t        cfg,
  input  ipm_pkg::prot_state_t state,
  output ipm_pkg::prot_state_t state_nxt,
  output ipm_pkg::out_item_t   result
);
  import ipm_pkg::*;

  logic signed [CUR_W-1:0] iu, iv, iw;
  logic [PEAK_W-1:0]       mu, mv, mw, peak;
  logic [THR_W-1:0]        bus, tm, td;
  logic [THR_W-1:0]        on_thr, off_thr, under_thr, over_thr;
  logic [FLAGS_W-1:0]      hit;
  logic                    chopper;

  always_comb begin
    iu = signed'({2'b00, frame.adc_phase_u}) - signed'(MID_CUR);
    iv = signed'({2'b00, frame.adc_phase_v}) - signed'(MID_CUR);
    iw = -(iu + iv);
    mu = iu[CUR_W-1] ? PEAK_W'(-iu) : PEAK_W'(iu);
    mv = iv[CUR_W-1] ? PEAK_W'(-iv) : PEAK_W'(iv);
    mw = iw[CUR_W-1] ? PEAK_W'(-iw) : PEAK_W'(iw);
    peak = mu;
    if (mv > peak) peak = mv;
    if (mw > peak) peak = mw;
  end

  always_comb begin
    bus = {1'b0, frame.adc_bus};
    tm  = {1'b0, frame.adc_temp_motor};
    td  = {1'b0, frame.adc_temp_driver};
    if (cfg.bus_high_voltage) begin
      on_thr = HV_ON_THR; off_thr = HV_OFF_THR;
      under_thr = HV_UNDER_THR; over_thr = HV_OVER_THR;
    end else begin
      on_thr = LV_ON_THR; off_thr = LV_OFF_THR;
      under_thr = LV_UNDER_THR; over_thr = LV_OVER_THR;
    end

    priority if (bus >= on_thr) chopper = 1'b1;
    else if (bus <= off_thr)    chopper = 1'b0;
    else                        chopper = state.chopper;

    hit            = '0;
    hit[FLAG_BUS]  = (bus < under_thr) || (bus > over_thr);
    hit[FLAG_OC]   = peak > cfg.overcurrent_limit;
    hit[FLAG_TEMP] = (tm > TEMP_THR) || (td > TEMP_THR);
    hit[FLAG_DRV]  = frame.driver_fault;

    state_nxt.chopper = chopper;
    state_nxt.flags   = state.flags | hit;

    result.drive_allowed = (frame.target_nonzero | frame.brake_hold) && (state.flags == '0);
    result.chopper_on    = chopper;
    result.gate_kill     = |hit;
    result.fault_flags   = state.flags | hit;
    result.peak_current  = peak;
  end

endmodule

// ===== rtl/core/ipm_checker.sv =====
// ----------------------------------------------------------------------------
// ipm_checker
// Port-level checks on the protection monitor: reset, result hold under
// stall, sticky fault flags, drive permission and gate kill.
// ----------------------------------------------------------------------------
module ipm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input ipm_pkg::in_item_t   in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ipm_pkg::out_item_t  out_data
);
  import ipm_pkg::*;

  logic [FLAGS_W-1:0] last_flags_r;
  logic               out_xfer;
  logic               in_xfer;

  assign out_xfer = out_valid && out_ready;
  assign in_xfer  = in_valid && in_ready && (in_data.driver_fault || !in_data.driver_fault);

  // flags of the last result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_flags_r <= '0;
    end else if (out_xfer) begin
      last_flags_r <= out_data.fault_flags;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> ((out_data.fault_flags & last_flags_r) == last_flags_r))
    else $error("fault flag cleared");

  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_data.drive_allowed |-> last_flags_r == '0)
    else $error("drive allowed with earlier fault");

  a_kill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.gate_kill |-> out_data.fault_flags != '0 || in_xfer)
    else $error("gate kill without fault flag");

endmodule

bind inverter_protection_monitor ipm_checker u_ipm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/protection_checker.sv =====
// ----------------------------------------------------------------------------
// protection_checker
// Watches the frame, result and register channels of the inverter protection
// monitor. It keeps its own copy of the bus range, current limit, chopper
// state and sticky fault flags. For every frame transfer it works out the
// result the block must return. It compares every result transfer field by
// field with the oldest outstanding prediction, and reports the failure count
// and the number of results still outstanding.
// ----------------------------------------------------------------------------
module protection_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  ipm_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  ipm_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ipm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import ipm_pkg::*;

  localparam int FULL_CODE = (1 << ADC_BITS) - 1;
  localparam int MIDSCALE  = 1 << (ADC_BITS - 1);

  // bus limits in volts, temperatures in degrees
  localparam int LO_SCALE    = 60;
  localparam int LO_ON       = 54;
  localparam int LO_OFF      = 51;
  localparam int LO_UNDER    = 36;
  localparam int LO_OVER     = 58;
  localparam int HI_SCALE    = 450;
  localparam int HI_ON       = 440;
  localparam int HI_OFF      = 410;
  localparam int HI_UNDER    = 300;
  localparam int HI_OVER     = 480;
  localparam int TEMP_FS_C   = 125;
  localparam int TEMP_TRIP_C = 105;

  logic               bus_hv;
  logic [LIMIT_W-1:0] oc_limit;
  logic               chopper_q;
  logic [FLAGS_W-1:0] sticky_flags;
  out_item_t          predicted_results [$];
  out_item_t          want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // exact compare of code/FS*scale against a limit
  function automatic int scaled_cmp(logic [ADC_BITS-1:0] code, int scale, int lim);
    longint lhs = longint'(code) * scale;
    longint rhs = longint'(lim) * FULL_CODE;
    return (lhs < rhs) ? -1 : ((lhs > rhs) ? 1 : 0);
  endfunction

  function automatic out_item_t evaluate_frame(in_item_t f);
    out_item_t          r;
    logic [FLAGS_W-1:0] hit;
    int                 iu, iv, iw, peak, scl, on_v, off_v, und_v, ovr_v;
    hit = '0;
    r.drive_allowed = (f.target_nonzero || f.brake_hold) && (sticky_flags == '0);

    if (bus_hv) begin
      scl = HI_SCALE; on_v = HI_ON; off_v = HI_OFF; und_v = HI_UNDER; ovr_v = HI_OVER;
    end else begin
      scl = LO_SCALE; on_v = LO_ON; off_v = LO_OFF; und_v = LO_UNDER; ovr_v = LO_OVER;
    end
    if (scaled_cmp(f.adc_bus, scl, on_v) >= 0) begin
      chopper_q = 1'b1;
    end else if (scaled_cmp(f.adc_bus, scl, off_v) <= 0) begin
      chopper_q = 1'b0;
    end
    if (scaled_cmp(f.adc_bus, scl, und_v) < 0 || scaled_cmp(f.adc_bus, scl, ovr_v) > 0) begin
      hit[FLAG_BUS] = 1'b1;
    end

    // third phase from the other two
    iu = int'(f.adc_phase_u) - MIDSCALE;
    iv = int'(f.adc_phase_v) - MIDSCALE;
    iw = -(iu + iv);
    peak = (iu < 0) ? -iu : iu;
    if (((iv < 0) ? -iv : iv) > peak) peak = (iv < 0) ? -iv : iv;
    if (((iw < 0) ? -iw : iw) > peak) peak = (iw < 0) ? -iw : iw;
    if (peak > int'(oc_limit)) begin
      hit[FLAG_OC] = 1'b1;
    end

    if (scaled_cmp(f.adc_temp_motor, TEMP_FS_C, TEMP_TRIP_C) > 0 ||
        scaled_cmp(f.adc_temp_driver, TEMP_FS_C, TEMP_TRIP_C) > 0) begin
      hit[FLAG_TEMP] = 1'b1;
    end
    if (f.driver_fault) begin
      hit[FLAG_DRV] = 1'b1;
    end

    sticky_flags   = sticky_flags | hit;
    r.chopper_on   = chopper_q;
    r.gate_kill    = |hit;
    r.fault_flags  = sticky_flags;
    r.peak_current = PEAK_W'(peak);
    return r;
  endfunction

  task automatic check_field(string name, logic [PEAK_W-1:0] expv, logic [PEAK_W-1:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bus_hv       = BUS_HV_RST;
      oc_limit     = OC_LIMIT_RST;
      chopper_q    = 1'b0;
      sticky_flags = '0;
      predicted_results.delete();
      pending      = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BUS_HV:   bus_hv   = cfg_data[0];
          REG_OC_LIMIT: oc_limit = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result transfer with no frame outstanding: %h", out_data);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("drive_allowed", want.drive_allowed, out_data.drive_allowed);
          check_field("chopper_on", want.chopper_on, out_data.chopper_on);
          check_field("gate_kill", want.gate_kill, out_data.gate_kill);
          check_field("fault_flags", want.fault_flags, out_data.fault_flags);
          check_field("peak_current", want.peak_current, out_data.peak_current);
        end
      end
      if (in_valid && in_ready) begin
        predicted_results.push_back(evaluate_frame(in_data));
      end
      pending = predicted_results.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the inverter protection monitor. A short directed
// run walks the chopper hysteresis ties in both bus ranges and the current
// limit edges. Random fault-free frames then run under several range and
// limit settings, followed by a directed pass over every fault source and
// then unconstrained frames. Sender gaps and receiver stalls change from
// phase to phase. Checking is done by protection_checker.
// ----------------------------------------------------------------------------
module testbench;
  import ipm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  // raw codes that keep bus and temperatures inside their limits
  localparam int HV_SAFE_MIN   = 2730;
  localparam int LV_SAFE_MIN   = 2457;
  localparam int LV_SAFE_MAX   = 3958;
  localparam int TEMP_SAFE_MAX = 3439;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int   fail_count;
  int   pending;
  int   idle_pct     = 0;
  int   stall_pct    = 0;
  int   stall_cycles = 0;
  logic cur_hv       = BUS_HV_RST;
  int   cur_limit    = int'(OC_LIMIT_RST);
  int   clean_limit [8] = '{1024, 4096, 0, 1500, 4096, 0, 2500, 700};
  int   noise_limit [4] = '{8191, 0, 4096, 1024};

  inverter_protection_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  protection_checker u_prot_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic in_item_t make_frame(int u, int v, int bus, int tm, int td,
                                          bit drv, bit tgt, bit hold);
    in_item_t f;
    f.adc_phase_u     = ADC_BITS'(u);
    f.adc_phase_v     = ADC_BITS'(v);
    f.adc_bus         = ADC_BITS'(bus);
    f.adc_temp_motor  = ADC_BITS'(tm);
    f.adc_temp_driver = ADC_BITS'(td);
    f.driver_fault    = drv;
    f.target_nonzero  = tgt;
    f.brake_hold      = hold;
    return f;
  endfunction

  // no fault source trips: |U|, |V| <= limit/2 keeps |W| within the limit too
  function automatic in_item_t clean_frame();
    in_item_t f;
    int       h;
    h = ((cur_limit > ADC_MID) ? ADC_MID : cur_limit) / 2;
    f.adc_phase_u     = ADC_BITS'(ADC_MID + int'($urandom_range(2 * h)) - h);
    f.adc_phase_v     = ADC_BITS'(ADC_MID + int'($urandom_range(2 * h)) - h);
    f.adc_bus         = cur_hv ? ADC_BITS'($urandom_range(ADC_FS, HV_SAFE_MIN))
                               : ADC_BITS'($urandom_range(LV_SAFE_MAX, LV_SAFE_MIN));
    f.adc_temp_motor  = ADC_BITS'($urandom_range(TEMP_SAFE_MAX));
    f.adc_temp_driver = ADC_BITS'($urandom_range(TEMP_SAFE_MAX));
    f.driver_fault    = 1'b0;
    f.target_nonzero  = 1'($urandom_range(1));
    f.brake_hold      = 1'($urandom_range(1));
    return f;
  endfunction

  function automatic in_item_t noise_frame();
    in_item_t f;
    f.adc_phase_u     = ADC_BITS'($urandom);
    f.adc_phase_v     = ADC_BITS'($urandom);
    f.adc_bus         = ADC_BITS'($urandom);
    f.adc_temp_motor  = ADC_BITS'($urandom);
    f.adc_temp_driver = ADC_BITS'($urandom);
    f.driver_fault    = 1'($urandom_range(1));
    f.target_nonzero  = 1'($urandom_range(1));
    f.brake_hold      = 1'($urandom_range(1));
    return f;
  endfunction

  task automatic push_frame(in_item_t f);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and let every outstanding result drain
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_config(logic hv, int limit);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BUS_HV;
    cfg_data  <= CFG_DATA_W'(hv);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_OC_LIMIT;
    cfg_data  <= CFG_DATA_W'(limit);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_hv    = hv;
    cur_limit = limit;
  endtask

  task automatic set_idling(int phase);
    case (phase)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 80; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 80; end
      default: begin idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // high range after reset, limit 1024: hysteresis ties, limit edge
    push_frame(make_frame(2048, 2048, 3185, 0, 0, 0, 0, 0));
    push_frame(make_frame(2048, 2048, 4003, 0, 0, 0, 1, 0));
    push_frame(make_frame(1024, 2048, 4004, 3439, 3439, 0, 0, 1));
    push_frame(make_frame(3072, 2048, 3800, 0, 0, 0, 1, 1));
    push_frame(make_frame(2048, 3072, 3732, 0, 0, 0, 1, 0));
    push_frame(make_frame(2048, 2048, 3731, 0, 0, 0, 1, 0));
    push_frame(make_frame(2048, 2048, 2730, 0, 0, 0, 1, 0));
    push_frame(make_frame(2048, 2048, 4095, 0, 0, 0, 1, 0));

    // low range: hysteresis ties, largest peaks at limit 4096
    settle();
    write_config(1'b0, 4096);
    push_frame(make_frame(0, 0, 3600, 0, 0, 0, 1, 0));
    push_frame(make_frame(4095, 4095, 3480, 0, 0, 0, 1, 0));
    push_frame(make_frame(4095, 0, 3685, 0, 0, 0, 1, 1));
    push_frame(make_frame(2048, 2048, 3686, 0, 0, 0, 0, 1));
    push_frame(make_frame(2048, 2048, 3958, 0, 0, 0, 1, 0));
    push_frame(make_frame(2048, 2048, 2457, 0, 0, 0, 1, 0));

    for (int k = 0; k < 8; k++) begin
      settle();
      set_idling(k % 4);
      write_config(!k[0], clean_limit[k]);
      repeat (125) push_frame(clean_frame());
    end

    // each fault source in turn
    settle();
    set_idling(0);
    write_config(1'b1, 1024);
    push_frame(make_frame(2048, 2048, 2729, 0, 0, 0, 1, 0));
    push_frame(make_frame(2048, 2048, 3185, 0, 0, 0, 1, 0));
    push_frame(make_frame(1023, 2048, 3185, 0, 0, 0, 1, 0));
    push_frame(make_frame(2048, 2048, 3185, 3440, 0, 0, 1, 0));
    push_frame(make_frame(2048, 2048, 3185, 0, 3440, 0, 1, 0));
    push_frame(make_frame(2048, 2048, 3185, 0, 0, 1, 1, 1));
    settle();
    write_config(1'b0, 0);
    push_frame(make_frame(2049, 2048, 3959, 0, 0, 0, 0, 0));
    push_frame(make_frame(2048, 2048, 2456, 4095, 4095, 1, 1, 1));
    push_frame(make_frame(4095, 4095, 4095, 4095, 4095, 1, 1, 1));
    push_frame(make_frame(0, 0, 0, 0, 0, 0, 0, 0));

    for (int k = 0; k < 4; k++) begin
      settle();
      set_idling(k);
      write_config(k[0], noise_limit[k]);
      repeat (100) push_frame(noise_frame());
    end

    settle();
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
